// ===== hw/rtl/lwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Layered window table package
// Shared sizes, codes and transaction types for the window table.
// ----------------------------------------------------------------------------
package lwt_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_WINDOWS = 16;
   localparam int SLOT_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

   // Operation codes.
   localparam logic [3:0] OP_CREATE     = 4'd0;
   localparam logic [3:0] OP_CHK_OWNER  = 4'd1;
   localparam logic [3:0] OP_CHK_CONT   = 4'd2;
   localparam logic [3:0] OP_COMMIT     = 4'd3;
   localparam logic [3:0] OP_RAISE      = 4'd4;
   localparam logic [3:0] OP_VISIBLE    = 4'd5;
   localparam logic [3:0] OP_DECORATE   = 4'd6;
   localparam logic [3:0] OP_MOVE       = 4'd7;
   localparam logic [3:0] OP_RESIZE     = 4'd8;
   localparam logic [3:0] OP_DESTROY    = 4'd9;
   localparam logic [3:0] OP_FRAME      = 4'd10;

   // Status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_INVALID    = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_NOT_OWNER  = 3'd4;
   localparam logic [2:0] ST_NOT_NEWER  = 3'd5;

   // Layer codes.
   localparam logic [1:0] LAYER_DESKTOP = 2'd0;
   localparam logic [1:0] LAYER_NORMAL  = 2'd1;

   // Register indexes (selected by paddr bit 2) and reset values.
   localparam logic REG_BORDER = 1'b0;
   localparam logic REG_TITLE  = 1'b1;
   localparam logic [7:0] BORDER_RESET = 8'd2;
   localparam logic [7:0] TITLE_RESET  = 8'd24;

   typedef struct packed {
      logic [3:0]         op;
      logic [4:0]         handle_id;
      logic [31:0]        handle_gen;
      logic [63:0]        owner_identity;
      logic [31:0]        content_seq;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        size_w;
      logic [31:0]        size_h;
      logic [1:0]         layer;
      logic               flag_value;
      logic               raise_on_show;
   } win_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [4:0]         result_id;
      logic [31:0]        result_generation;
      logic signed [31:0] frame_x;
      logic signed [31:0] frame_y;
      logic signed [31:0] frame_w;
      logic signed [31:0] frame_h;
      logic               focusable;
   } win_rsp_type;

endpackage

// ===== hw/rtl/layered_window_table.sv =====
// ----------------------------------------------------------------------------
// Layered window table
// Handle-addressed table of window slots with a layered stacking list.
// ----------------------------------------------------------------------------
// Sequence: a decode reject goes straight to the result; lookup ops read the slot once;
// create scans for the lowest free slot and shifts up stacking entries of a higher layer;
// raise walks the stacking list to the slot and past its run of equal layer; destroy
// walks the list to the slot and closes the gap behind it.
// Throughput: one transaction at a time; busy stays high until the result, no stall.
// Reset: synchronous; clears control state and slot valid bits, no sweep.
module layered_window_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lwt_pkg::win_req_type req_data,
   output logic                rsp_strobe,
   output lwt_pkg::win_rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import lwt_pkg::*;

   // Per-slot record kept in the slot memory.
   typedef struct packed {
      logic [31:0] generation;
      logic [31:0] content_gen;
      logic        visible;
      logic        decorated;
      logic [31:0] geo_x;
      logic [31:0] geo_y;
      logic [31:0] geo_w;
      logic [31:0] geo_h;
      logic [63:0] owner;
   } slot_rec_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_CR_SCAN, S_CR_GEN, S_INS_RD, S_INS_CHK, S_LOOKUP,
      S_FIND_RD, S_FIND_CHK, S_RAISE_RD, S_RAISE_CHK, S_DEL_RD, S_DEL_CHK,
      S_DESTROY_CLR, S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   win_req_type           req_ff, req_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      live_ff, live_in;
   logic [2:0]            status_ff, status_in;
   logic                  has_slot_ff, has_slot_in;
   logic                  raise_mode_ff, raise_mode_in;
   slot_rec_type          rec_ff, rec_in;
   logic [MAX_WINDOWS-1:0] active_ff, active_in;
   logic [MAX_WINDOWS-1:0] valid_ff, valid_in;
   logic [1:0]            layer_ff [MAX_WINDOWS];
   logic [1:0]            layer_in [MAX_WINDOWS];
   logic                  rsp_strobe_ff, rsp_strobe_in;
   win_rsp_type           rsp_ff, rsp_in;
   logic [7:0]            border_ff, title_ff;

   // Memories and their ports.
   slot_rec_type          slot_mem [MAX_WINDOWS];
   slot_rec_type          slot_rd_ff;
   logic                  slot_rd_valid_ff;
   logic                  slot_re, slot_we;
   logic [SLOT_W-1:0]     slot_raddr;
   slot_rec_type          slot_wdata;
   slot_rec_type          slot_rd_rec;
   logic [SLOT_W-1:0]     z_mem [MAX_WINDOWS];
   logic [SLOT_W-1:0]     z_rd_ff;
   logic                  z_re, z_we;
   logic [SLOT_W-1:0]     z_raddr, z_waddr, z_wdata;

   logic [CNT_W-1:0]      pos_next;
   logic                  owner_ok;
   logic [31:0]           gen_bump;
   logic [31:0]           fx, fy, fw, fh;

   // Slot memory: registered read, unwritten entries read as the reset record.
   always_ff @(posedge clock) begin
      if (slot_re) begin
         slot_rd_ff       <= slot_mem[slot_raddr];
         slot_rd_valid_ff <= valid_ff[slot_raddr];
      end
      if (slot_we) begin
         slot_mem[slot_in] <= slot_wdata;
      end
   end

   assign slot_rd_rec = slot_rd_valid_ff ? slot_rd_ff : '0;

   // Stacking memory: only entries below the live count are ever read.
   always_ff @(posedge clock) begin
      if (z_re) begin
         z_rd_ff <= z_mem[z_raddr];
      end
      if (z_we) begin
         z_mem[z_waddr] <= z_wdata;
      end
   end

   // Configuration registers.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TITLE) ? {24'd0, title_ff} : {24'd0, border_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff <= BORDER_RESET;
         title_ff  <= TITLE_RESET;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_BORDER) begin
            border_ff <= pwdata[7:0];
         end else begin
            title_ff <= pwdata[7:0];
         end
      end
   end

   // Helpers used by several states.
   assign pos_next = pos_ff + CNT_W'(1);
   assign gen_bump = (slot_rd_rec.generation == 32'hFFFF_FFFF) ? 32'd1
                                                               : slot_rd_rec.generation + 32'd1;
   assign owner_ok = (slot_rd_rec.owner[63:32] != 32'd0) && (slot_rd_rec.owner[31:0] != 32'd0)
                     && (slot_rd_rec.owner == req_ff.owner_identity);

   // Frame of the working record with decoration borders.
   always_comb begin
      fx = rec_ff.geo_x;
      fy = rec_ff.geo_y;
      fw = rec_ff.geo_w;
      fh = rec_ff.geo_h;
      if (rec_ff.decorated) begin
         fx = rec_ff.geo_x - {24'd0, border_ff};
         fy = rec_ff.geo_y - {24'd0, title_ff};
         fw = rec_ff.geo_w + {23'd0, border_ff, 1'b0};
         fh = rec_ff.geo_h + {24'd0, title_ff} + {24'd0, border_ff};
      end
   end

   // Sequencer next-state logic and memory control.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      slot_in       = slot_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      live_in       = live_ff;
      status_in     = status_ff;
      has_slot_in   = has_slot_ff;
      raise_mode_in = raise_mode_ff;
      rec_in        = rec_ff;
      active_in     = active_ff;
      valid_in      = valid_ff;
      layer_in      = layer_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      slot_re       = 1'b0;
      slot_raddr    = slot_ff;
      slot_we       = 1'b0;
      slot_wdata    = rec_ff;
      z_re          = 1'b0;
      z_raddr       = pos_ff[SLOT_W-1:0];
      z_we          = 1'b0;
      z_waddr       = pos_ff[SLOT_W-1:0];
      z_wdata       = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_data;
               status_in   = ST_OK;
               has_slot_in = 1'b0;
               state_in    = S_DECODE;
            end
         end

         // Argument and handle checks.
         S_DECODE: begin
            if (req_ff.op == OP_CREATE) begin
               if (req_ff.owner_identity[63:32] == 32'd0 ||
                   req_ff.owner_identity[31:0] == 32'd0 ||
                   req_ff.content_seq == 32'd0 ||
                   req_ff.size_w == 32'd0 || req_ff.size_h == 32'd0) begin
                  status_in = ST_INVALID;
                  state_in  = S_EMIT;
               end else if (32'(live_ff) >= 32'(MAX_WINDOWS)) begin
                  status_in = ST_FULL;
                  state_in  = S_EMIT;
               end else begin
                  scan_in  = '0;
                  state_in = S_CR_SCAN;
               end
            end else if (req_ff.op > OP_FRAME) begin
               status_in = ST_INVALID;
               state_in  = S_EMIT;
            end else if (req_ff.handle_id == 5'd0 ||
                         32'(req_ff.handle_id) > 32'(MAX_WINDOWS) ||
                         req_ff.handle_gen == 32'd0) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_EMIT;
            end else begin
               slot_in    = SLOT_W'(32'(req_ff.handle_id) - 32'd1);
               slot_re    = 1'b1;
               slot_raddr = SLOT_W'(32'(req_ff.handle_id) - 32'd1);
               state_in   = S_LOOKUP;
            end
         end

         // Walk the active bits for the lowest free slot.
         S_CR_SCAN: begin
            if (!active_ff[scan_ff]) begin
               slot_in    = scan_ff;
               slot_re    = 1'b1;
               slot_raddr = scan_ff;
               state_in   = S_CR_GEN;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end

         // Fill the new record with a bumped generation.
         S_CR_GEN: begin
            rec_in.generation  = gen_bump;
            rec_in.content_gen = req_ff.content_seq;
            rec_in.visible     = 1'b1;
            rec_in.decorated   = 1'b0;
            rec_in.geo_x       = req_ff.pos_x;
            rec_in.geo_y       = req_ff.pos_y;
            rec_in.geo_w       = req_ff.size_w;
            rec_in.geo_h       = req_ff.size_h;
            rec_in.owner       = req_ff.owner_identity;
            slot_we            = 1'b1;
            slot_wdata         = rec_in;
            valid_in[slot_ff]  = 1'b1;
            active_in[slot_ff] = 1'b1;
            layer_in[slot_ff]  = req_ff.layer;
            has_slot_in        = 1'b1;
            pos_in             = live_ff;
            state_in           = S_INS_RD;
         end

         // Insertion: shift up entries of a higher layer, from the top down.
         S_INS_RD: begin
            if (pos_ff == '0) begin
               z_we     = 1'b1;
               live_in  = live_ff + CNT_W'(1);
               state_in = S_EMIT;
            end else begin
               z_re     = 1'b1;
               z_raddr  = SLOT_W'(pos_ff - CNT_W'(1));
               state_in = S_INS_CHK;
            end
         end

         S_INS_CHK: begin
            z_we = 1'b1;
            if (layer_ff[z_rd_ff] > req_ff.layer) begin
               z_wdata  = z_rd_ff;
               pos_in   = pos_ff - CNT_W'(1);
               state_in = S_INS_RD;
            end else begin
               live_in  = live_ff + CNT_W'(1);
               state_in = S_EMIT;
            end
         end

         // Handle match and per-op record update.
         S_LOOKUP: begin
            rec_in = slot_rd_rec;
            if (!active_ff[slot_ff] || slot_rd_rec.generation != req_ff.handle_gen) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_EMIT;
            end else begin
               has_slot_in = 1'b1;
               state_in    = S_EMIT;
               pos_in      = '0;
               case (req_ff.op)
                  OP_CHK_OWNER, OP_CHK_CONT: begin
                     if (!owner_ok) begin
                        status_in = ST_NOT_OWNER;
                     end else if (req_ff.op == OP_CHK_CONT &&
                                  (req_ff.content_seq == 32'd0 ||
                                   req_ff.content_seq <= slot_rd_rec.content_gen)) begin
                        status_in = ST_NOT_NEWER;
                     end
                  end
                  OP_COMMIT: begin
                     rec_in.content_gen = req_ff.content_seq;
                     slot_we            = 1'b1;
                     slot_wdata         = rec_in;
                  end
                  OP_RAISE: begin
                     raise_mode_in = 1'b1;
                     state_in      = S_FIND_RD;
                  end
                  OP_VISIBLE: begin
                     rec_in.visible = req_ff.flag_value;
                     slot_we        = 1'b1;
                     slot_wdata     = rec_in;
                     if (req_ff.flag_value && req_ff.raise_on_show) begin
                        raise_mode_in = 1'b1;
                        state_in      = S_FIND_RD;
                     end
                  end
                  OP_DECORATE: begin
                     rec_in.decorated = req_ff.flag_value;
                     slot_we          = 1'b1;
                     slot_wdata       = rec_in;
                  end
                  OP_MOVE: begin
                     rec_in.geo_x = req_ff.pos_x;
                     rec_in.geo_y = req_ff.pos_y;
                     slot_we      = 1'b1;
                     slot_wdata   = rec_in;
                  end
                  OP_RESIZE: begin
                     if (req_ff.size_w == 32'd0 || req_ff.size_h == 32'd0) begin
                        status_in = ST_INVALID;
                     end else begin
                        rec_in.geo_w = req_ff.size_w;
                        rec_in.geo_h = req_ff.size_h;
                        slot_we      = 1'b1;
                        slot_wdata   = rec_in;
                     end
                  end
                  OP_DESTROY: begin
                     raise_mode_in = 1'b0;
                     state_in      = S_FIND_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Locate the slot in the stacking list.
         S_FIND_RD: begin
            if (pos_ff >= live_ff) begin
               state_in = raise_mode_ff ? S_EMIT : S_DESTROY_CLR;
            end else begin
               z_re     = 1'b1;
               state_in = S_FIND_CHK;
            end
         end

         S_FIND_CHK: begin
            if (z_rd_ff == slot_ff) begin
               state_in = raise_mode_ff ? S_RAISE_RD : S_DEL_RD;
            end else begin
               pos_in   = pos_next;
               state_in = S_FIND_RD;
            end
         end

         // Raise: move the slot to the top of its run of equal layer.
         S_RAISE_RD: begin
            if (pos_next >= live_ff) begin
               z_we     = 1'b1;
               state_in = S_EMIT;
            end else begin
               z_re     = 1'b1;
               z_raddr  = pos_next[SLOT_W-1:0];
               state_in = S_RAISE_CHK;
            end
         end

         S_RAISE_CHK: begin
            z_we = 1'b1;
            if (layer_ff[z_rd_ff] == layer_ff[slot_ff]) begin
               z_wdata  = z_rd_ff;
               pos_in   = pos_next;
               state_in = S_RAISE_RD;
            end else begin
               state_in = S_EMIT;
            end
         end

         // Destroy: close the gap in the stacking list.
         S_DEL_RD: begin
            if (pos_next >= live_ff) begin
               live_in  = live_ff - CNT_W'(1);
               state_in = S_DESTROY_CLR;
            end else begin
               z_re     = 1'b1;
               z_raddr  = pos_next[SLOT_W-1:0];
               state_in = S_DEL_CHK;
            end
         end

         S_DEL_CHK: begin
            z_we     = 1'b1;
            z_wdata  = z_rd_ff;
            pos_in   = pos_next;
            state_in = S_DEL_RD;
         end

         // Clear the slot but keep its generation.
         S_DESTROY_CLR: begin
            rec_in             = '0;
            rec_in.generation  = rec_ff.generation;
            slot_we            = 1'b1;
            slot_wdata         = rec_in;
            active_in[slot_ff] = 1'b0;
            layer_in[slot_ff]  = LAYER_NORMAL;
            state_in           = S_EMIT;
         end

         // Build the result transaction.
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            rsp_in.status = status_ff;
            if (has_slot_ff) begin
               rsp_in.result_id         = 5'(32'(slot_ff) + 32'd1);
               rsp_in.result_generation = rec_ff.generation;
               if (active_ff[slot_ff]) begin
                  if (!rec_ff.geo_w[31] && !rec_ff.geo_h[31]) begin
                     rsp_in.frame_x = fx;
                     rsp_in.frame_y = fy;
                     rsp_in.frame_w = fw;
                     rsp_in.frame_h = fh;
                  end
                  rsp_in.focusable = rec_ff.visible && (layer_ff[slot_ff] != LAYER_DESKTOP);
               end
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         active_ff     <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            layer_ff[i] <= LAYER_NORMAL;
         end
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         active_ff     <= active_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         layer_ff      <= layer_in;
      end
      req_ff        <= req_in;
      slot_ff       <= slot_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      has_slot_ff   <= has_slot_in;
      raise_mode_ff <= raise_mode_in;
      rec_ff        <= rec_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // A result appears only right after the result state.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("result strobe without result state");

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // Between transactions the live count matches the active slots.
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(active_ff) == 32'(live_ff)))
      else $error("live count out of step with active slots");

   // The live count never exceeds the table size.
   a_live_max: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) <= 32'(MAX_WINDOWS))
      else $error("live count above table size");
`endif

endmodule

// ===== verif/lwt_checker.sv =====
// ----------------------------------------------------------------------------
// Layered window table checker
// Watches the command, result and register ports, predicts each result and
// compares it field by field with the one that the block returns.
// ----------------------------------------------------------------------------
module lwt_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  lwt_pkg::win_req_type req_data,
   input  logic                 rsp_strobe,
   input  lwt_pkg::win_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   pending
);
   import lwt_pkg::*;

   // Predicted copy of the table and the register settings.
   logic [7:0]        border_cfg;
   logic [7:0]        title_cfg;
   logic              win_active [MAX_WINDOWS];
   logic [31:0]       win_gen    [MAX_WINDOWS];
   logic [31:0]       win_cont   [MAX_WINDOWS];
   logic              win_vis    [MAX_WINDOWS];
   logic [1:0]        win_layer  [MAX_WINDOWS];
   logic              win_deco   [MAX_WINDOWS];
   logic [31:0]       win_x      [MAX_WINDOWS];
   logic [31:0]       win_y      [MAX_WINDOWS];
   logic [31:0]       win_w      [MAX_WINDOWS];
   logic [31:0]       win_h      [MAX_WINDOWS];
   logic [63:0]       win_owner  [MAX_WINDOWS];
   int                z_list     [MAX_WINDOWS];
   int                live_windows;
   win_rsp_type       expected_results [$];

   assign pending = expected_results.size();

   // Return a slot to its cleared state; the generation survives.
   task automatic clear_window(input int s);
      win_active[s] = 1'b0;
      win_cont[s]   = '0;
      win_vis[s]    = 1'b0;
      win_layer[s]  = LAYER_NORMAL;
      win_deco[s]   = 1'b0;
      win_x[s]      = '0;
      win_y[s]      = '0;
      win_w[s]      = '0;
      win_h[s]      = '0;
      win_owner[s]  = '0;
   endtask

   function automatic int z_index(input int s);
      for (int i = 0; i < live_windows; i++)
         if (z_list[i] == s) return i;
      return live_windows;
   endfunction

   // Move a window to the top of the run of windows that share its layer.
   task automatic raise_window(input int s);
      int at;
      int stop;
      at = z_index(s);
      if (!win_active[s] || at >= live_windows) return;
      stop = at + 1;
      while (stop < live_windows && win_layer[z_list[stop]] == win_layer[s])
         stop++;
      for (int i = at; i + 1 < stop; i++)
         z_list[i] = z_list[i + 1];
      z_list[stop - 1] = s;
   endtask

   task automatic destroy_window(input int s);
      int at;
      if (!win_active[s]) return;
      at = z_index(s);
      if (at < live_windows) begin
         for (int i = at; i + 1 < live_windows; i++)
            z_list[i] = z_list[i + 1];
         live_windows--;
      end
      clear_window(s);
   endtask

   // Take the lowest free slot and stack it above its layer's run.
   task automatic create_window(input win_req_type r, output int s);
      int at;
      s = -1;
      for (int i = 0; i < MAX_WINDOWS; i++)
         if (!win_active[i]) begin
            s = i;
            break;
         end
      if (s < 0) return;
      win_gen[s] = win_gen[s] + 32'd1;
      if (win_gen[s] == 32'd0) win_gen[s] = 32'd1;
      win_active[s] = 1'b1;
      win_cont[s]   = r.content_seq;
      win_vis[s]    = 1'b1;
      win_layer[s]  = r.layer;
      win_deco[s]   = 1'b0;
      win_x[s]      = r.pos_x;
      win_y[s]      = r.pos_y;
      win_w[s]      = r.size_w;
      win_h[s]      = r.size_h;
      win_owner[s]  = r.owner_identity;
      at = live_windows;
      while (at != 0 && win_layer[z_list[at - 1]] > r.layer) begin
         z_list[at] = z_list[at - 1];
         at--;
      end
      z_list[at] = s;
      live_windows++;
   endtask

   // Build the result for a status and an optional slot.
   function automatic win_rsp_type window_result(input logic [2:0] st, input int s);
      win_rsp_type e;
      e = '0;
      e.status = st;
      if (s < 0) return e;
      e.result_id = 5'(s + 1);
      e.result_generation = win_gen[s];
      if (win_active[s]) begin
         if (!win_w[s][31] && !win_h[s][31]) begin
            if (win_deco[s]) begin
               e.frame_x = win_x[s] - 32'(border_cfg);
               e.frame_y = win_y[s] - 32'(title_cfg);
               e.frame_w = win_w[s] + 32'(border_cfg) * 2;
               e.frame_h = win_h[s] + 32'(title_cfg) + 32'(border_cfg);
            end else begin
               e.frame_x = win_x[s];
               e.frame_y = win_y[s];
               e.frame_w = win_w[s];
               e.frame_h = win_h[s];
            end
         end
         e.focusable = win_vis[s] && (win_layer[s] != LAYER_DESKTOP);
      end
      return e;
   endfunction

   // Apply one command to the predicted table and return its result.
   task automatic predict_window_op(input win_req_type r, output win_rsp_type e);
      int s;
      logic [2:0] st;
      logic [63:0] own;
      st = ST_OK;
      if (r.op == OP_CREATE) begin
         if (r.owner_identity[63:32] == 0 || r.owner_identity[31:0] == 0 ||
             r.content_seq == 0 || r.size_w == 0 || r.size_h == 0) begin
            e = window_result(ST_INVALID, -1);
         end else if (live_windows >= MAX_WINDOWS) begin
            e = window_result(ST_FULL, -1);
         end else begin
            create_window(r, s);
            e = window_result((s < 0) ? ST_FULL : ST_OK, s);
         end
         return;
      end
      if (r.op > OP_FRAME) begin
         e = window_result(ST_INVALID, -1);
         return;
      end
      if (r.handle_id == 0 || r.handle_id > MAX_WINDOWS || r.handle_gen == 0 ||
          !win_active[r.handle_id - 1] ||
          win_gen[r.handle_id - 1] != r.handle_gen) begin
         e = window_result(ST_NOT_FOUND, -1);
         return;
      end
      s = r.handle_id - 1;
      own = win_owner[s];
      case (r.op)
         OP_CHK_OWNER, OP_CHK_CONT: begin
            if (own[63:32] == 0 || own[31:0] == 0 || own != r.owner_identity)
               st = ST_NOT_OWNER;
            else if (r.op == OP_CHK_CONT &&
                     (r.content_seq == 0 || r.content_seq <= win_cont[s]))
               st = ST_NOT_NEWER;
         end
         OP_COMMIT: win_cont[s] = r.content_seq;
         OP_RAISE: raise_window(s);
         OP_VISIBLE: begin
            win_vis[s] = r.flag_value;
            if (r.flag_value && r.raise_on_show) raise_window(s);
         end
         OP_DECORATE: win_deco[s] = r.flag_value;
         OP_MOVE: begin
            win_x[s] = r.pos_x;
            win_y[s] = r.pos_y;
         end
         OP_RESIZE: begin
            if (r.size_w == 0 || r.size_h == 0) begin
               st = ST_INVALID;
            end else begin
               win_w[s] = r.size_w;
               win_h[s] = r.size_h;
            end
         end
         OP_DESTROY: destroy_window(s);
         default: ;
      endcase
      e = window_result(st, s);
   endtask

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Track register writes, accepted commands and returned results.
   always @(posedge clock) begin
      win_req_type r;
      win_rsp_type e;
      if (reset) begin
         border_cfg = BORDER_RESET;
         title_cfg  = TITLE_RESET;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            clear_window(i);
            win_gen[i] = '0;
            z_list[i]  = 0;
         end
         live_windows = 0;
         fail_count   = 0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_BORDER) border_cfg = pwdata[7:0];
            else title_cfg = pwdata[7:0];
         end
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("result transaction arrived with no command outstanding");
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               compare_field("status", e.status, rsp_data.status);
               compare_field("result_id", e.result_id, rsp_data.result_id);
               compare_field("result_generation", e.result_generation,
                             rsp_data.result_generation);
               compare_field("frame_x", e.frame_x, rsp_data.frame_x);
               compare_field("frame_y", e.frame_y, rsp_data.frame_y);
               compare_field("frame_w", e.frame_w, rsp_data.frame_w);
               compare_field("frame_h", e.frame_h, rsp_data.frame_h);
               compare_field("focusable", e.focusable, rsp_data.focusable);
            end
         end
         if (start && !busy) begin
            r = req_data;
            predict_window_op(r, e);
            expected_results.push_back(e);
         end
      end
   end

endmodule

// ===== verif/tb_layered_window_table.sv =====
// ----------------------------------------------------------------------------
// Layered window table testbench
// Drives directed and random window commands with random gaps, changes the
// decoration registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_layered_window_table;
   import lwt_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1630;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   win_req_type req_data;
   logic        rsp_strobe;
   win_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          idle_cycles;

   // Handles that the stimulus knows to be live.
   logic        known_live  [MAX_WINDOWS];
   logic [31:0] known_gen   [MAX_WINDOWS];
   logic [63:0] known_owner [MAX_WINDOWS];
   logic [31:0] known_cont  [MAX_WINDOWS];
   win_rsp_type last_result;

   layered_window_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lwt_checker lwt_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on cycles in which no transaction moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("layered_window_table regression: fail");
            $finish;
         end
      end
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 70);
   endfunction

   // Register write: setup cycle, then access cycle.
   task automatic write_reg(input logic sel, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= {16'd0, 8'($urandom_range(0, 255)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Issue one command, wait for its result, and track handle changes.
   task automatic send_command(input win_req_type r);
      int s;
      repeat (gap_length()) @(posedge clock);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      do @(posedge clock); while (!rsp_strobe);
      last_result = rsp_data;
      s = int'(rsp_data.result_id) - 1;
      if (rsp_data.status == ST_OK && s >= 0 && s < MAX_WINDOWS) begin
         case (r.op)
            OP_CREATE: begin
               known_live[s]  = 1'b1;
               known_gen[s]   = rsp_data.result_generation;
               known_owner[s] = r.owner_identity;
               known_cont[s]  = r.content_seq;
            end
            OP_COMMIT:  known_cont[s] = r.content_seq;
            OP_DESTROY: known_live[s] = 1'b0;
            default: ;
         endcase
      end
   endtask

   function automatic win_req_type random_bits();
      logic [287:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom};
      return raw[$bits(win_req_type)-1:0];
   endfunction

   // A valid create with random content; sizes mostly modest.
   function automatic win_req_type good_create();
      win_req_type r;
      r = random_bits();
      r.op = OP_CREATE;
      r.owner_identity[63:32] = $urandom_range(1, 6);
      r.owner_identity[31:0]  = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) r.owner_identity = {$urandom, $urandom} | 64'h1_0000_0001;
      r.content_seq = $urandom_range(1, 40);
      if ($urandom_range(0, 9) != 0) begin
         r.size_w = $urandom_range(1, 4000);
         r.size_h = $urandom_range(1, 4000);
      end
      if (r.size_w == 0) r.size_w = 1;
      if (r.size_h == 0) r.size_h = 1;
      return r;
   endfunction

   // Mostly well-formed commands on live handles, with some noise.
   function automatic win_req_type random_command();
      win_req_type r;
      int s;
      int p;
      r = random_bits();
      p = $urandom_range(0, 99);
      if (p < 4) return r;
      s = -1;
      for (int k = 0; k < 4 && s < 0; k++) begin
         s = $urandom_range(0, MAX_WINDOWS - 1);
         if (!known_live[s]) s = -1;
      end
      if (p < 28 || s < 0) begin
         r = good_create();
         if ($urandom_range(0, 12) == 0) begin
            case ($urandom_range(0, 4))
               0: r.owner_identity[63:32] = '0;
               1: r.owner_identity[31:0] = '0;
               2: r.content_seq = '0;
               3: r.size_w = '0;
               default: r.size_h = '0;
            endcase
         end
         return r;
      end
      r.op = (p < 36) ? OP_DESTROY : 4'($urandom_range(1, 10));
      r.handle_id = 5'(s + 1);
      r.handle_gen = known_gen[s];
      if ($urandom_range(0, 3) != 0) r.owner_identity = known_owner[s];
      r.content_seq = known_cont[s] + 32'($urandom_range(0, 3)) - 32'd1;
      if ($urandom_range(0, 5) != 0) begin
         r.size_w = $urandom_range(0, 3000);
         r.size_h = $urandom_range(0, 3000);
      end
      if ($urandom_range(0, 9) == 0) r.handle_gen = known_gen[s] + 32'd1;
      return r;
   endfunction

   task automatic config_phase(input int phase);
      logic [7:0] b;
      logic [7:0] t;
      case (phase % 4)
         0: begin b = 8'd0;   t = 8'd0;   end
         1: begin b = 8'd255; t = 8'd255; end
         2: begin b = 8'd0;   t = 8'd255; end
         default: begin b = 8'($urandom); t = 8'($urandom); end
      endcase
      write_reg(REG_BORDER, b);
      write_reg(REG_TITLE, t);
   endtask

   initial begin
      win_req_type r;
      int handle;
      logic [31:0] hgen;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         known_live[i]  = 1'b0;
         known_gen[i]   = '0;
         known_owner[i] = '0;
         known_cont[i]  = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: invalid create arguments, one create per layer at extremes.
      for (int k = 0; k < 5; k++) begin
         r = good_create();
         case (k)
            0: r.owner_identity[63:32] = '0;
            1: r.owner_identity[31:0] = '0;
            2: r.content_seq = '0;
            3: r.size_w = '0;
            default: r.size_h = '0;
         endcase
         send_command(r);
      end
      for (int k = 0; k < 4; k++) begin
         r = good_create();
         r.layer = 2'(3 - k);
         r.pos_x = (k % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
         r.pos_y = (k % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         if (k == 3) r.size_w = 32'hffff_ffff;
         send_command(r);
      end
      handle = int'(last_result.result_id);
      hgen   = last_result.result_generation;
      // Directed: every lookup op except destroy on the last created window.
      for (int k = 1; k <= 10; k++) begin
         r = random_bits();
         r.op = 4'(k == 10 ? OP_FRAME : (k == 9 ? OP_RESIZE : k));
         r.handle_id = 5'(handle);
         r.handle_gen = hgen;
         r.owner_identity = known_owner[handle - 1];
         r.flag_value = (k != 5);
         r.raise_on_show = 1'b1;
         if (k == 9) r.size_w = '0;
         send_command(r);
      end
      // Directed: bad handles and unknown ops.
      r = random_bits(); r.op = OP_FRAME; r.handle_id = '0; send_command(r);
      r.handle_id = 5'd17; send_command(r);
      r.handle_id = 5'(handle); r.handle_gen = '0; send_command(r);
      r.op = 4'd11; send_command(r);
      r.op = 4'd15; send_command(r);

      // Random phases, with register changes while the block is idle.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 0) begin
            while (pending != 0) @(posedge clock);
            repeat (8) @(posedge clock);
            config_phase(n / 300);
         end
         send_command(random_command());
      end

      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("layered_window_table regression: pass");
      end else begin
         $display("layered_window_table regression: fail");
      end
      $finish;
   end

endmodule
